@@ rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types, codes and symbol decode for the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;

   // characters
   localparam logic [7:0] CH_OPEN_ROUND  = 8'h28;
   localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
   localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
   localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
   localparam logic [7:0] CH_BAR          = 8'h7C;

   // bracket kinds
   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_CURLY  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // status codes
   localparam logic [2:0] ST_FINE            = 3'd0;
   localparam logic [2:0] ST_ACCEPT          = 3'd1;
   localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd2;
   localparam logic [2:0] ST_MISMATCH        = 3'd3;
   localparam logic [2:0] ST_UNMATCHED_OPEN  = 3'd4;
   localparam logic [2:0] ST_OVERFLOW        = 3'd5;

   // stack operations
   localparam logic [1:0] STK_HOLD = 2'd0;
   localparam logic [1:0] STK_PUSH = 2'd1;
   localparam logic [1:0] STK_POP  = 2'd2;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       expression_done;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] kind;
   } stk_cmd_type;

   function automatic logic [1:0] open_kind(input logic [7:0] c);
      logic [1:0] k;
      unique case (c)
         CH_OPEN_ROUND:  k = KIND_ROUND;
         CH_OPEN_SQUARE: k = KIND_SQUARE;
         CH_OPEN_CURLY:  k = KIND_CURLY;
         default:        k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [1:0] close_kind(input logic [7:0] c);
      logic [1:0] k;
      unique case (c)
         CH_CLOSE_ROUND:  k = KIND_ROUND;
         CH_CLOSE_SQUARE: k = KIND_SQUARE;
         CH_CLOSE_CURLY:  k = KIND_CURLY;
         default:         k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/bbc_cell.sv @@
// ----------------------------------------------------------------------------
// bbc_cell
// one stack entry; shifts down on push, up on pop
// ----------------------------------------------------------------------------
module bbc_cell
   import bbc_pkg::*;
(
   input  logic        clock,
   input  logic [1:0]  op,
   input  logic [1:0]  from_above,
   input  logic [1:0]  from_below,
   output logic [1:0]  kind
);

   logic [1:0] kind_ff;
   logic [1:0] kind_in;

   always_comb begin
      unique case (op)
         STK_PUSH: kind_in = from_above;
         STK_POP:  kind_in = from_below;
         default:  kind_in = kind_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

@@ rtl/bbc_stack.sv @@
// ----------------------------------------------------------------------------
// bbc_stack
// row of cells forming the opener stack, top of stack in the first cell
// ----------------------------------------------------------------------------
module bbc_stack
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  stk_cmd_type cmd,
   output logic [1:0]  top_kind
);

   logic [1:0] kinds [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [1:0] above;
      logic [1:0] below;

      if (i == 0) begin : g_first
         assign above = cmd.kind;
      end else begin : g_inner_a
         assign above = kinds[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = kinds[i];
      end else begin : g_inner_b
         assign below = kinds[i+1];
      end

      bbc_cell u_cell (
         .clock      (clock),
         .op         (cmd.op),
         .from_above (above),
         .from_below (below),
         .kind       (kinds[i])
      );
   end

   assign top_kind = kinds[0];

endmodule

@@ rtl/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks nesting of round, square and curly brackets and absolute-value bars
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   req_data (symbol, is_last)
//  rsp_      out        rsp_valid / rsp_ready   rsp_data (status, expression_done)
//
//  one transfer per cycle while req_ready is high; result is registered and appears in the cycle after the req transfer
//  stack push and pop shift the whole cell row in that same cycle
//  req_ready falls only while an untaken result sits in the output register
//  reset clears count, bar flag, error and output valid; no clearing pass
// ----------------------------------------------------------------------------
module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in, count_after;
   logic             bar_ff, bar_in, bar_after;
   logic [2:0]       err_ff, err_in, err_new;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             err_free;
   logic             full;
   logic             empty;
   logic [1:0]       ok;
   logic [1:0]       ck;
   logic             is_open;
   logic             is_close;
   logic             is_bar;
   logic             push;
   logic             pop;
   logic [1:0]       top_kind;
   logic [2:0]       status;
   stk_cmd_type      cmd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign ok       = open_kind(req_data.symbol);
   assign ck       = close_kind(req_data.symbol);
   assign is_open  = (ok != KIND_NONE);
   assign is_close = (ck != KIND_NONE);
   assign is_bar   = (req_data.symbol == CH_BAR);
   assign err_free = (err_ff == ST_FINE);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty    = (count_ff == '0);

   assign push = accept && err_free && is_open && !full;
   assign pop  = accept && err_free && is_close && !empty;

   always_comb begin
      err_new = err_ff;
      if (err_free) begin
         if (is_open && full) begin
            err_new = ST_OVERFLOW;
         end else if (is_close && empty) begin
            err_new = ST_UNMATCHED_CLOSE;
         end else if (is_close && top_kind != ck) begin
            err_new = ST_MISMATCH;
         end
      end
   end

   always_comb begin
      count_after = count_ff;
      if (push) begin
         count_after = count_ff + CNT_W'(1);
      end else if (pop) begin
         count_after = count_ff - CNT_W'(1);
      end
   end

   assign bar_after = bar_ff ^ (err_free && is_bar);

   always_comb begin
      if (err_new != ST_FINE) begin
         status = err_new;
      end else if (!req_data.is_last) begin
         status = ST_FINE;
      end else if (count_after != '0 || bar_after) begin
         status = ST_UNMATCHED_OPEN;
      end else begin
         status = ST_ACCEPT;
      end
   end

   always_comb begin
      cmd.kind = ok;
      cmd.op   = push ? STK_PUSH : (pop ? STK_POP : STK_HOLD);
   end

   bbc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .cmd      (cmd),
      .top_kind (top_kind)
   );

   always_comb begin
      count_in = count_ff;
      bar_in   = bar_ff;
      err_in   = err_ff;
      if (accept) begin
         if (req_data.is_last) begin
            count_in = '0;
            bar_in   = 1'b0;
            err_in   = ST_FINE;
         end else begin
            count_in = count_after;
            bar_in   = bar_after;
            err_in   = err_new;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = status;
         rsp_data_in.expression_done = req_data.is_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bar_ff       <= 1'b0;
         err_ff       <= ST_FINE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         bar_ff       <= bar_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.is_last |=> count_ff == '0 && !bar_ff && err_ff == ST_FINE)
      else $error("state not cleared after last transfer");

   a_verdict_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.expression_done |->
         rsp_data.status != ST_ACCEPT && rsp_data.status != ST_UNMATCHED_OPEN)
      else $error("verdict status before end of expression");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff != ST_FINE && !(accept && req_data.is_last) |=> err_ff == $past(err_ff))
      else $error("sticky error changed");

endmodule
